/* sv/ctb_pkg.sv */
// ----------------------------------------------------------------------------
// ctb_pkg
// shared constants, register indexes and width helpers of the checker tile
// select pipeline
// ----------------------------------------------------------------------------
package ctb_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int COORD_W       = 32;
    localparam int TRIG_W        = 18;
    localparam int SHIFT_W       = 32;
    localparam int TILE_W        = 31;
    localparam int MOD_W         = TILE_W + 1;
    localparam int PROD_W        = COORD_W + TRIG_W;
    localparam int SUM_W         = PROD_W + 1;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int BITS_PER_STG  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_COS   = 3'd0,
        REG_ROT_SIN   = 3'd1,
        REG_SHIFT_X   = 3'd2,
        REG_SHIFT_Z   = 3'd3,
        REG_TILE_SIZE = 3'd4
    } t_cfg_reg;

    // width of the rotated and shifted coordinate
    function automatic int calc_axis_w(input int frac_bits);
        int w;
        w = SUM_W - frac_bits;
        if (w < SHIFT_W) begin
            w = SHIFT_W;
        end
        return w + 1;
    endfunction

endpackage

/* sv/checkerboard_tile_select_top.sv */
// ----------------------------------------------------------------------------
// checkerboard_tile_select_top
// checker floor color lookup at a rotated and shifted hit point
// ----------------------------------------------------------------------------
// usage:
//   input channel i_valid/o_ready carries i_hit_x, i_hit_z (signed fixed
//   point); output channel o_valid/i_ready carries o_tile_white (1 white)
//   config channel i_cfg_valid/o_cfg_ready writes i_cfg_data to register
//   i_cfg_index: 0 cos, 1 sin, 2 shift x, 3 shift z, 4 tile size; others
//   are dropped; o_cfg_ready is always high; write only while idle
// timing:
//   three rotation stages, ceil(axis width / 2) remainder stages (18 at the
//   default 16 fraction bits) and one output register; one request taken
//   every cycle unless the output stalls with every stage full
//   the remainder pipeline, two dividend bits per stage, sets the depth
// reset and stall:
//   reset empties the pipeline and loads cos 1.0, sin 0, shifts 0, tile 1.0
//   a stalled output holds; empty stages still fill, o_ready falls only
//   when every stage holds a request
// ----------------------------------------------------------------------------
module checkerboard_tile_select_top #(
    parameter int FRAC_BITS = ctb_pkg::DEF_FRAC_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [ctb_pkg::COORD_W-1:0]     i_hit_x,
    input  logic signed [ctb_pkg::COORD_W-1:0]     i_hit_z,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_tile_white,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ctb_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ctb_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import ctb_pkg::*;

    localparam int AXIS_W = calc_axis_w(FRAC_BITS);
    localparam int NSTG   = (AXIS_W + BITS_PER_STG - 1) / BITS_PER_STG;
    localparam int DVD_W  = NSTG * BITS_PER_STG;
    localparam int NV     = NSTG + 4;

    logic signed [TRIG_W-1:0]  r_cos, r_sin;
    logic signed [SHIFT_W-1:0] r_shift_x, r_shift_z;
    logic [TILE_W-1:0]         r_tile;
    logic [TILE_W-1:0]         w_tile_eff;
    logic [MOD_W-1:0]          w_mod;

    logic [NV-1:0] r_v;
    logic [NV:0]   w_en;

    logic              w_neg_x, w_neg_z;
    logic [AXIS_W-1:0] w_mag_x, w_mag_z;

    logic [MOD_W-1:0] w_rem_x [0:NSTG];
    logic [MOD_W-1:0] w_rem_z [0:NSTG];
    logic [DVD_W-1:0] w_dvd_x [0:NSTG];
    logic [DVD_W-1:0] w_dvd_z [0:NSTG];
    logic             w_sgn_x [0:NSTG];
    logic             w_sgn_z [0:NSTG];

    logic r_white, n_white_x, n_white_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos     <= TRIG_W'(1 << FRAC_BITS);
            r_sin     <= '0;
            r_shift_x <= '0;
            r_shift_z <= '0;
            r_tile    <= TILE_W'(1 << FRAC_BITS);
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_ROT_COS:   r_cos     <= i_cfg_data[TRIG_W-1:0];
                REG_ROT_SIN:   r_sin     <= i_cfg_data[TRIG_W-1:0];
                REG_SHIFT_X:   r_shift_x <= i_cfg_data[SHIFT_W-1:0];
                REG_SHIFT_Z:   r_shift_z <= i_cfg_data[SHIFT_W-1:0];
                REG_TILE_SIZE: r_tile    <= i_cfg_data[TILE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_tile_eff  = (r_tile == '0) ? TILE_W'(1) : r_tile;
    assign w_mod       = {w_tile_eff, 1'b0};

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_en[NV] = i_ready;
        for (int k = NV - 1; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NV; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_ready = w_en[0];

    ctb_rotate #(
        .FRAC_BITS (FRAC_BITS),
        .AXIS_W    (AXIS_W)
    ) u_rotate (
        .i_clk     (i_clk),
        .i_en      (w_en[2:0]),
        .i_hit_x   (i_hit_x),
        .i_hit_z   (i_hit_z),
        .i_cos     (r_cos),
        .i_sin     (r_sin),
        .i_shift_x (r_shift_x),
        .i_shift_z (r_shift_z),
        .o_neg_x   (w_neg_x),
        .o_mag_x   (w_mag_x),
        .o_neg_z   (w_neg_z),
        .o_mag_z   (w_mag_z)
    );

    assign w_rem_x[0] = '0;
    assign w_rem_z[0] = '0;
    assign w_dvd_x[0] = DVD_W'(w_mag_x);
    assign w_dvd_z[0] = DVD_W'(w_mag_z);
    assign w_sgn_x[0] = w_neg_x;
    assign w_sgn_z[0] = w_neg_z;

    for (genvar g = 0; g < NSTG; g++) begin : g_rem
        ctb_rem_stage #(.DVD_W(DVD_W)) u_rem_x (
            .i_clk (i_clk),
            .i_en  (w_en[3+g]),
            .i_mod (w_mod),
            .i_rem (w_rem_x[g]),
            .i_dvd (w_dvd_x[g]),
            .i_neg (w_sgn_x[g]),
            .o_rem (w_rem_x[g+1]),
            .o_dvd (w_dvd_x[g+1]),
            .o_neg (w_sgn_x[g+1])
        );
        ctb_rem_stage #(.DVD_W(DVD_W)) u_rem_z (
            .i_clk (i_clk),
            .i_en  (w_en[3+g]),
            .i_mod (w_mod),
            .i_rem (w_rem_z[g]),
            .i_dvd (w_dvd_z[g]),
            .i_neg (w_sgn_z[g]),
            .o_rem (w_rem_z[g+1]),
            .o_dvd (w_dvd_z[g+1]),
            .o_neg (w_sgn_z[g+1])
        );
    end

    // negative side: remainder is minus the magnitude remainder
    always_comb begin
        if (w_sgn_x[NSTG]) begin
            n_white_x = (w_rem_x[NSTG] > MOD_W'(w_tile_eff)) || (w_rem_x[NSTG] == '0);
        end else begin
            n_white_x = w_rem_x[NSTG] < MOD_W'(w_tile_eff);
        end
        if (w_sgn_z[NSTG]) begin
            n_white_z = (w_rem_z[NSTG] > MOD_W'(w_tile_eff)) || (w_rem_z[NSTG] == '0);
        end else begin
            n_white_z = w_rem_z[NSTG] < MOD_W'(w_tile_eff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NV-1]) begin
            r_white <= n_white_x ^ n_white_z;
        end
    end

    assign o_valid      = r_v[NV-1];
    assign o_tile_white = r_white;

    // input side blocks only when the whole pipeline is full and stalled
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v) && !i_ready)
        else $error("input stalled with a free stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tile_white))
        else $error("stalled result lost or changed");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_v[0])
        else $error("accepted request not captured");

endmodule

/* sv/ctb_rotate.sv */
// ----------------------------------------------------------------------------
// ctb_rotate
// three stage rotation, floor scaling, shift subtract and sign split
// ----------------------------------------------------------------------------
module ctb_rotate #(
    parameter int FRAC_BITS = ctb_pkg::DEF_FRAC_BITS,
    parameter int AXIS_W    = ctb_pkg::calc_axis_w(ctb_pkg::DEF_FRAC_BITS)
) (
    input  logic                                i_clk,
    input  logic [2:0]                          i_en,
    input  logic signed [ctb_pkg::COORD_W-1:0]  i_hit_x,
    input  logic signed [ctb_pkg::COORD_W-1:0]  i_hit_z,
    input  logic signed [ctb_pkg::TRIG_W-1:0]   i_cos,
    input  logic signed [ctb_pkg::TRIG_W-1:0]   i_sin,
    input  logic signed [ctb_pkg::SHIFT_W-1:0]  i_shift_x,
    input  logic signed [ctb_pkg::SHIFT_W-1:0]  i_shift_z,
    output logic                                o_neg_x,
    output logic [AXIS_W-1:0]                   o_mag_x,
    output logic                                o_neg_z,
    output logic [AXIS_W-1:0]                   o_mag_z
);
    import ctb_pkg::*;

    logic signed [PROD_W-1:0] r_pxc, r_pzs, r_pzc, r_pxs;
    logic signed [SUM_W-1:0]  n_sx, n_sz;
    logic signed [AXIS_W-1:0] r_ax, r_az, n_ax, n_az;
    logic                     r_neg_x, r_neg_z;
    logic [AXIS_W-1:0]        r_mag_x, r_mag_z;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_pxc <= i_hit_x * i_cos;
            r_pzs <= i_hit_z * i_sin;
            r_pzc <= i_hit_z * i_cos;
            r_pxs <= i_hit_x * i_sin;
        end
    end

    always_comb begin
        n_sx = SUM_W'(r_pxc) + SUM_W'(r_pzs);
        n_sz = SUM_W'(r_pzc) - SUM_W'(r_pxs);
        // arithmetic shift is a floor toward minus infinity
        n_ax = AXIS_W'(n_sx >>> FRAC_BITS) - AXIS_W'(i_shift_x);
        n_az = AXIS_W'(n_sz >>> FRAC_BITS) - AXIS_W'(i_shift_z);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_ax <= n_ax;
            r_az <= n_az;
        end
        if (i_en[2]) begin
            r_neg_x <= r_ax[AXIS_W-1];
            r_neg_z <= r_az[AXIS_W-1];
            r_mag_x <= r_ax[AXIS_W-1] ? AXIS_W'(-r_ax) : AXIS_W'(r_ax);
            r_mag_z <= r_az[AXIS_W-1] ? AXIS_W'(-r_az) : AXIS_W'(r_az);
        end
    end

    assign o_neg_x = r_neg_x;
    assign o_mag_x = r_mag_x;
    assign o_neg_z = r_neg_z;
    assign o_mag_z = r_mag_z;

endmodule

/* sv/ctb_rem_stage.sv */
// ----------------------------------------------------------------------------
// ctb_rem_stage
// one stage of the restoring remainder pipeline, two dividend bits a stage
// ----------------------------------------------------------------------------
module ctb_rem_stage #(
    parameter int DVD_W = 38
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ctb_pkg::MOD_W-1:0]  i_mod,
    input  logic [ctb_pkg::MOD_W-1:0]  i_rem,
    input  logic [DVD_W-1:0]           i_dvd,
    input  logic                       i_neg,
    output logic [ctb_pkg::MOD_W-1:0]  o_rem,
    output logic [DVD_W-1:0]           o_dvd,
    output logic                       o_neg
);
    import ctb_pkg::*;

    logic [MOD_W-1:0] n_rem, r_rem;
    logic [DVD_W-1:0] n_dvd, r_dvd;
    logic             r_neg;
    logic [MOD_W:0]   v_try;

    always_comb begin
        n_rem = i_rem;
        n_dvd = i_dvd;
        v_try = '0;
        for (int j = 0; j < BITS_PER_STG; j++) begin
            v_try = {n_rem, n_dvd[DVD_W-1]};
            n_dvd = n_dvd << 1;
            if (v_try >= {1'b0, i_mod}) begin
                v_try = v_try - {1'b0, i_mod};
            end
            n_rem = v_try[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_dvd <= n_dvd;
            r_neg <= i_neg;
        end
    end

    assign o_rem = r_rem;
    assign o_dvd = r_dvd;
    assign o_neg = r_neg;

endmodule
